// ----- rtl/core/bb3_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bb3_pkg;

    // Default sizing of the frame stores
    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 4096;

    // Field widths
    localparam int CH_W           = 8;
    localparam int PIX_W          = 3 * CH_W;
    localparam int SUM_W          = 12;   // nine 8-bit samples
    localparam int FRAME_WIDTH_W  = 12;
    localparam int FRAME_HEIGHT_W = 13;

    // APB register file
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam logic [FRAME_WIDTH_W-1:0]  RESET_FRAME_WIDTH  = 12'd640;
    localparam logic [FRAME_HEIGHT_W-1:0] RESET_FRAME_HEIGHT = 13'd480;

    // Reciprocals for divide by 3 and by 9, exact for sums below 2^12
    localparam int RECIP_W     = 15;
    localparam int RECIP_SHIFT = 16;
    localparam logic [RECIP_W-1:0] RECIP_3 = 15'd21846;
    localparam logic [RECIP_W-1:0] RECIP_9 = 15'd7282;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_OUTPUT
    } t_state;

    typedef enum logic [2:0] {
        DIV_1,
        DIV_2,
        DIV_3,
        DIV_4,
        DIV_6,
        DIV_9
    } t_div;

    // Per-item control worked out when the beat is taken
    typedef struct packed {
        logic produced;
        logic last;
        logic top_out;
        logic bottom_out;
        logic left_out;
        logic right_out;
    } t_ctl;

    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
    } t_rgb_sum;

    // Divisor from the number of in-frame rows and columns
    function automatic t_div div_code(input t_ctl ctl);
        logic [1:0] rows;
        logic [1:0] cols;
        t_div       d;
        rows = 2'd3 - 2'(ctl.top_out) - 2'(ctl.bottom_out);
        cols = 2'd3 - 2'(ctl.left_out) - 2'(ctl.right_out);
        unique case ({rows, cols})
            4'b0101: d = DIV_1;
            4'b0110, 4'b1001: d = DIV_2;
            4'b0111, 4'b1101: d = DIV_3;
            4'b1010: d = DIV_4;
            4'b1011, 4'b1110: d = DIV_6;
            4'b1111: d = DIV_9;
            default: d = DIV_1;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/box_blur_3x3_rgb.sv -----
// A result is valid on the output once the beat that completes its neighbourhood has
// passed the update and output states, one line plus one pixel behind the input.
// A new beat is taken only after the previous one's line-store read, write-back and
// output load around the single-port-read memory; the load waits on a stalled output.
// Reset (i_rst_n low, synchronous): counters, window and state machine cleared,
// frame size set to 640 x 480; the line stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module box_blur_3x3_rgb #(
    parameter int MAX_WIDTH  = bb3_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bb3_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // APB configuration port
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [bb3_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [bb3_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [bb3_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready,
    // Pixel input
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic                           i_action,
    input  wire logic [bb3_pkg::CH_W-1:0]       i_red_in,
    input  wire logic [bb3_pkg::CH_W-1:0]       i_green_in,
    input  wire logic [bb3_pkg::CH_W-1:0]       i_blue_in,
    // Pixel output
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [bb3_pkg::CH_W-1:0]            o_red_out,
    output logic [bb3_pkg::CH_W-1:0]            o_green_out,
    output logic [bb3_pkg::CH_W-1:0]            o_blue_out,
    output logic                                o_last_of_frame
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WD_W  = $clog2(MAX_WIDTH + 1);
    localparam int HT_W  = $clog2(MAX_HEIGHT + 1);
    localparam int ROW_W = $clog2(MAX_HEIGHT + 2);
    localparam int PW    = bb3_pkg::PIX_W;

    // Configuration
    logic [bb3_pkg::FRAME_WIDTH_W-1:0]  r_frame_width;
    logic [bb3_pkg::FRAME_HEIGHT_W-1:0] r_frame_height;
    logic                               cfg_write;
    logic [WD_W-1:0]                    w_eff;
    logic [HT_W-1:0]                    h_eff;

    // Position and per-item state
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_addr;
    logic [PW-1:0]     r_pix;
    bb3_pkg::t_ctl     r_ctl, n_ctl;
    logic [ROW_W-1:0]  yc;
    logic [COL_W-1:0]  xc;

    // Control
    bb3_pkg::t_state   r_state, n_state;
    logic              accept;
    logic              mem_re;
    logic              win_shift;
    logic              div_load;
    logic              div_busy;

    logic [2*PW-1:0]   mem_rdata;
    bb3_pkg::t_rgb_sum win_sum;
    bb3_pkg::t_div     win_div;

    // APB
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == bb3_pkg::REG_FRAME_HEIGHT) ?
                       bb3_pkg::APB_DATA_W'(r_frame_height) :
                       bb3_pkg::APB_DATA_W'(r_frame_width);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= bb3_pkg::RESET_FRAME_WIDTH;
            r_frame_height <= bb3_pkg::RESET_FRAME_HEIGHT;
        end else if (cfg_write) begin
            priority if (paddr[2] == bb3_pkg::REG_FRAME_WIDTH) begin
                r_frame_width <= pwdata[bb3_pkg::FRAME_WIDTH_W-1:0];
            end else begin
                r_frame_height <= pwdata[bb3_pkg::FRAME_HEIGHT_W-1:0];
            end
        end
    end

    // Clamp frame size to 1 .. maximum
    always_comb begin
        if (r_frame_width == '0) begin
            w_eff = WD_W'(1);
        end else if (32'(r_frame_width) > 32'(MAX_WIDTH)) begin
            w_eff = WD_W'(MAX_WIDTH);
        end else begin
            w_eff = WD_W'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            h_eff = HT_W'(1);
        end else if (32'(r_frame_height) > 32'(MAX_HEIGHT)) begin
            h_eff = HT_W'(MAX_HEIGHT);
        end else begin
            h_eff = HT_W'(r_frame_height);
        end
    end

    // Output position, border flags and next counters for the item at the head
    always_comb begin
        n_ctl.produced = (32'(r_row) >= 32'd2) || (32'(r_row) == 32'd1 && r_col != '0);
        n_ctl.last     = 32'(r_row) >= 32'(h_eff) + 32'd1;
        if (r_col != '0) begin
            yc = r_row - ROW_W'(1);
            xc = r_col - COL_W'(1);
        end else begin
            yc = r_row - ROW_W'(2);
            xc = COL_W'(w_eff - WD_W'(1));
        end
        n_ctl.top_out    = yc == '0;
        n_ctl.bottom_out = 32'(yc) + 32'd1 >= 32'(h_eff);
        n_ctl.left_out   = xc == '0;
        n_ctl.right_out  = 32'(xc) + 32'd1 >= 32'(w_eff);

        if (n_ctl.last) begin
            n_col = '0;
            n_row = '0;
        end else if (32'(r_col) + 32'd1 >= 32'(w_eff)) begin
            n_col = '0;
            n_row = r_row + ROW_W'(1);
        end else begin
            n_col = r_col + COL_W'(1);
            n_row = r_row;
        end
    end

    // Position counters; any register write rewinds the frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_ctl <= '0;
        end else if (cfg_write) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
            r_ctl <= n_ctl;
        end
    end

    // Beat payload; a flush step enters as black
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_addr <= r_col;
            r_pix  <= i_action ? '0 : {i_red_in, i_green_in, i_blue_in};
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bb3_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b1;
        accept     = 1'b0;
        mem_re     = 1'b0;
        win_shift  = 1'b0;
        div_load   = 1'b0;
        unique case (r_state)
            bb3_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    accept  = 1'b1;
                    mem_re  = 1'b1;
                    n_state = bb3_pkg::ST_UPDATE;
                end
            end
            bb3_pkg::ST_UPDATE: begin
                win_shift = 1'b1;
                n_state   = bb3_pkg::ST_OUTPUT;
            end
            bb3_pkg::ST_OUTPUT: begin
                if (!r_ctl.produced) begin
                    n_state = bb3_pkg::ST_IDLE;
                end else if (!div_busy) begin
                    div_load = 1'b1;
                    n_state  = bb3_pkg::ST_IDLE;
                end
            end
            default: n_state = bb3_pkg::ST_IDLE;
        endcase
    end

    // Line stores: upper half is the row two above, lower half the row above
    bb3_ram #(
        .WIDTH (2 * PW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (win_shift),
        .i_waddr (r_addr),
        .i_wdata ({mem_rdata[PW-1:0], r_pix}),
        .i_re    (mem_re),
        .i_raddr (r_col),
        .o_rdata (mem_rdata)
    );

    bb3_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (win_shift),
        .i_top   (mem_rdata[2*PW-1:PW]),
        .i_mid   (mem_rdata[PW-1:0]),
        .i_pix   (r_pix),
        .i_ctl   (r_ctl),
        .o_sum   (win_sum),
        .o_div   (win_div)
    );

    bb3_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (div_load),
        .i_sum       (win_sum),
        .i_div       (win_div),
        .i_last      (r_ctl.last),
        .i_out_stall (i_out_stall),
        .o_busy      (div_busy),
        .o_out_valid (o_out_valid),
        .o_red       (o_red_out),
        .o_green     (o_green_out),
        .o_blue      (o_blue_out),
        .o_last      (o_last_of_frame)
    );

`ifndef SYNTHESIS
    // A taken beat always moves on to the line-store write-back
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == bb3_pkg::ST_UPDATE))
        else $error("beat taken without line-store update");

    // Column counter stays inside the configured line
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_col) < 32'(w_eff))
        else $error("column counter outside frame width");

    // Row counter never passes the flush row
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_row) <= 32'(h_eff) + 32'd1)
        else $error("row counter past flush row");

    // A result waiting on a stalled output keeps the sequencer parked
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bb3_pkg::ST_OUTPUT && r_ctl.produced && div_busy)
        |=> (r_state == bb3_pkg::ST_OUTPUT))
        else $error("result dropped while output stalled");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/bb3_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bb3_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/bb3_window.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bb3_window (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_shift,
    input  wire logic [bb3_pkg::PIX_W-1:0] i_top,
    input  wire logic [bb3_pkg::PIX_W-1:0] i_mid,
    input  wire logic [bb3_pkg::PIX_W-1:0] i_pix,
    input  wire bb3_pkg::t_ctl            i_ctl,
    output bb3_pkg::t_rgb_sum             o_sum,
    output bb3_pkg::t_div                 o_div
);

    localparam int CW = bb3_pkg::CH_W;
    localparam int SW = bb3_pkg::SUM_W;

    logic [bb3_pkg::PIX_W-1:0] r_win [3][3];
    logic [bb3_pkg::PIX_W-1:0] n_win [3][3];
    bb3_pkg::t_rgb_sum         n_sum;

    // Shift the window left and add the new column, then sum the kept cells
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_win[i][0] = r_win[i][1];
            n_win[i][1] = r_win[i][2];
        end
        n_win[0][2] = i_top;
        n_win[1][2] = i_mid;
        n_win[2][2] = i_pix;

        n_sum = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (!((i == 0 && i_ctl.top_out) || (i == 2 && i_ctl.bottom_out) ||
                      (j == 0 && i_ctl.left_out) || (j == 2 && i_ctl.right_out))) begin
                    n_sum.red   = n_sum.red   + SW'(n_win[i][j][3*CW-1:2*CW]);
                    n_sum.green = n_sum.green + SW'(n_win[i][j][2*CW-1:CW]);
                    n_sum.blue  = n_sum.blue  + SW'(n_win[i][j][CW-1:0]);
                end
            end
        end
    end

    // Window cells
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else if (i_shift) begin
            r_win <= n_win;
        end
    end

    // Sum and divisor register
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            o_sum <= n_sum;
            o_div <= bb3_pkg::div_code(i_ctl);
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/bb3_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bb3_div (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_load,
    input  wire bb3_pkg::t_rgb_sum        i_sum,
    input  wire bb3_pkg::t_div            i_div,
    input  wire logic                     i_last,
    input  wire logic                     i_out_stall,
    output logic                          o_busy,
    output logic                          o_out_valid,
    output logic [bb3_pkg::CH_W-1:0]      o_red,
    output logic [bb3_pkg::CH_W-1:0]      o_green,
    output logic [bb3_pkg::CH_W-1:0]      o_blue,
    output logic                          o_last
);

    localparam int SW = bb3_pkg::SUM_W;
    localparam int PW = bb3_pkg::SUM_W + bb3_pkg::RECIP_W;

    // Truncating divide by 1, 2, 3, 4, 6 or 9; six is a halving then a third
    function automatic logic [bb3_pkg::CH_W-1:0] div_ch(input logic [SW-1:0] s,
                                                       input bb3_pkg::t_div d);
        logic [SW-1:0]                   m;
        logic [bb3_pkg::RECIP_W-1:0]     k;
        logic [PW-1:0]                   p;
        logic [SW-1:0]                   q;
        m = (d == bb3_pkg::DIV_6) ? (s >> 1) : s;
        k = (d == bb3_pkg::DIV_9) ? bb3_pkg::RECIP_9 : bb3_pkg::RECIP_3;
        p = PW'(m) * PW'(k);
        unique case (d)
            bb3_pkg::DIV_1: q = s;
            bb3_pkg::DIV_2: q = s >> 1;
            bb3_pkg::DIV_4: q = s >> 2;
            default:        q = SW'(p >> bb3_pkg::RECIP_SHIFT);
        endcase
        return q[bb3_pkg::CH_W-1:0];
    endfunction

    logic r_valid;

    assign o_busy      = r_valid && i_out_stall;
    assign o_out_valid = r_valid;

    // Output beat valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            o_red   <= div_ch(i_sum.red, i_div);
            o_green <= div_ch(i_sum.green, i_div);
            o_blue  <= div_ch(i_sum.blue, i_div);
            o_last  <= i_last;
        end
    end

endmodule

`default_nettype wire

// ----- tb/blur_monitor.sv -----
`timescale 1ns / 1ps

// Watches the configuration port and both pixel channels, keeps its own blur state,
// checks register reads and compares every outgoing beat with the oldest predicted pixel.
module blur_monitor (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration port
    input  wire logic                           i_psel,
    input  wire logic                           i_penable,
    input  wire logic                           i_pwrite,
    input  wire logic [bb3_pkg::APB_ADDR_W-1:0] i_paddr,
    input  wire logic [bb3_pkg::APB_DATA_W-1:0] i_pwdata,
    input  wire logic [bb3_pkg::APB_DATA_W-1:0] i_prdata,
    input  wire logic                           i_pready,
    // pixel input channel
    input  wire logic                           i_in_valid,
    input  wire logic                           i_in_stall,
    input  wire logic                           i_action,
    input  wire logic [bb3_pkg::CH_W-1:0]       i_red_in,
    input  wire logic [bb3_pkg::CH_W-1:0]       i_green_in,
    input  wire logic [bb3_pkg::CH_W-1:0]       i_blue_in,
    // pixel output channel
    input  wire logic                           i_out_valid,
    input  wire logic                           i_out_stall,
    input  wire logic [bb3_pkg::CH_W-1:0]       i_red_out,
    input  wire logic [bb3_pkg::CH_W-1:0]       i_green_out,
    input  wire logic [bb3_pkg::CH_W-1:0]       i_blue_out,
    input  wire logic                           i_last_of_frame,
    // status for the stimulus side
    output int                                  o_fail_count,
    output int                                  o_pending
);

    localparam logic ACT_FLUSH = 1'b1;
    localparam int   MAXW      = bb3_pkg::DEF_MAX_WIDTH;
    localparam int   MAXH      = bb3_pkg::DEF_MAX_HEIGHT;
    localparam int   LOG_LIMIT = 200;

    typedef logic [bb3_pkg::PIX_W-1:0] rgb_t;

    typedef struct packed {
        logic [bb3_pkg::CH_W-1:0] red;
        logic [bb3_pkg::CH_W-1:0] green;
        logic [bb3_pkg::CH_W-1:0] blue;
        logic                     last;
    } blur_pixel_t;

    rgb_t                               upper_row [MAXW];
    rgb_t                               middle_row [MAXW];
    rgb_t                               win [3][3];
    int unsigned                        col_pos;
    int unsigned                        row_pos;
    logic [bb3_pkg::FRAME_WIDTH_W-1:0]  width_reg;
    logic [bb3_pkg::FRAME_HEIGHT_W-1:0] height_reg;
    blur_pixel_t                        blurred_pixels [$];
    int                                 n_bad = 0;

    initial begin
        for (int k = 0; k < MAXW; k++) begin
            upper_row[k]  = '0;
            middle_row[k] = '0;
        end
    end

    // zero means one, oversize is clipped to the store size
    function automatic int unsigned clamp_size(int unsigned v, int unsigned limit);
        if (v == 0) return 1;
        if (v > limit) return limit;
        return v;
    endfunction

    task automatic report(string what, int want, int got);
        n_bad++;
        // log limit
        if (n_bad <= LOG_LIMIT)
            $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
    endtask

    // One accepted beat: shift the line stores and window, and queue the blurred
    // pixel for the centre one line plus one pixel behind.
    task automatic advance_blur(logic act, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int unsigned w, h, c, rw, idx, yc, xc, cnt, sr, sg, sb;
        int unsigned rlo, rhi, clo, chi, i, j;
        rgb_t        pix, top_v, mid_v, v;
        logic        last;
        blur_pixel_t px;
        w    = clamp_size(width_reg, MAXW);
        h    = clamp_size(height_reg, MAXH);
        c    = col_pos;
        rw   = row_pos;
        idx  = (c < MAXW) ? c : MAXW - 1;
        last = (rw >= h + 1);
        pix  = (act == ACT_FLUSH) ? '0 : {r, g, b};

        top_v           = upper_row[idx];
        mid_v           = middle_row[idx];
        upper_row[idx]  = mid_v;
        middle_row[idx] = pix;

        for (i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = top_v;
        win[1][2] = mid_v;
        win[2][2] = pix;

        if (rw >= 2 || (rw == 1 && c >= 1)) begin
            if (c >= 1) begin
                yc = rw - 1;
                xc = c - 1;
            end else begin
                yc = rw - 2;
                xc = w - 1;
            end
            // only in-frame neighbours count
            rlo = (yc >= 1) ? 0 : 1;
            rhi = (yc + 1 < h) ? 2 : 1;
            clo = (xc >= 1) ? 0 : 1;
            chi = (xc + 1 < w) ? 2 : 1;
            cnt = 0;
            sr  = 0;
            sg  = 0;
            sb  = 0;
            for (i = rlo; i <= rhi; i++) begin
                for (j = clo; j <= chi; j++) begin
                    v   = win[i][j];
                    sr += v[23:16];
                    sg += v[15:8];
                    sb += v[7:0];
                    cnt++;
                end
            end
            px.red   = 8'(sr / cnt);
            px.green = 8'(sg / cnt);
            px.blue  = 8'(sb / cnt);
            px.last  = last;
            blurred_pixels.push_back(px);
        end

        // rewind after the frame's final flush
        if (last) begin
            col_pos = 0;
            row_pos = 0;
        end else begin
            c++;
            if (c >= w) begin
                c = 0;
                rw++;
            end
            col_pos = c;
            row_pos = rw;
        end
    endtask

    always @(posedge i_clk) begin
        blur_pixel_t                      want;
        logic [bb3_pkg::APB_DATA_W-1:0]  reg_value;
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    win[i][j] = '0;
            col_pos    = 0;
            row_pos    = 0;
            width_reg  = bb3_pkg::RESET_FRAME_WIDTH;
            height_reg = bb3_pkg::RESET_FRAME_HEIGHT;
            blurred_pixels.delete();
        end else begin
            // register access; bit 2 of the address selects the register
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    if (i_paddr[2] == bb3_pkg::REG_FRAME_WIDTH)
                        width_reg = i_pwdata[bb3_pkg::FRAME_WIDTH_W-1:0];
                    else
                        height_reg = i_pwdata[bb3_pkg::FRAME_HEIGHT_W-1:0];
                    col_pos = 0;
                    row_pos = 0;
                end else begin
                    reg_value = (i_paddr[2] == bb3_pkg::REG_FRAME_WIDTH) ?
                                32'(width_reg) : 32'(height_reg);
                    if (i_prdata !== reg_value)
                        report("register read", reg_value, i_prdata);
                end
            end

            // outgoing beat against the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                if (blurred_pixels.size() == 0) begin
                    n_bad++;
                    if (n_bad <= LOG_LIMIT)
                        $display("%0t ns: pixel expected none, got %0d/%0d/%0d last %0d",
                                 $time, i_red_out, i_green_out, i_blue_out,
                                 i_last_of_frame);
                end else begin
                    want = blurred_pixels.pop_front();
                    if (i_red_out !== want.red)
                        report("red", want.red, i_red_out);
                    if (i_green_out !== want.green)
                        report("green", want.green, i_green_out);
                    if (i_blue_out !== want.blue)
                        report("blue", want.blue, i_blue_out);
                    if (i_last_of_frame !== want.last)
                        report("last_of_frame", want.last, i_last_of_frame);
                end
            end

            if (i_in_valid && !i_in_stall)
                advance_blur(i_action, i_red_in, i_green_in, i_blue_in);
        end
        o_pending    <= blurred_pixels.size();
        o_fail_count <= n_bad;
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    localparam logic ACT_PIXEL     = 1'b0;
    localparam logic ACT_FLUSH     = 1'b1;
    localparam int   MAXW          = bb3_pkg::DEF_MAX_WIDTH;
    localparam int   MAXH          = bb3_pkg::DEF_MAX_HEIGHT;
    localparam int   CYCLE_LIMIT   = 1_000_000;
    localparam int   SETTLE_CYCLES = 8;
    localparam int   RANDOM_ITEMS  = 600;

    typedef enum {
        IDLE_SENDER_LIGHT,
        IDLE_SENDER_HEAVY,
        IDLE_NONE
    } idle_mode_t;

    logic                           i_clk   = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           psel    = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite  = 1'b0;
    logic [bb3_pkg::APB_ADDR_W-1:0] paddr   = '0;
    logic [bb3_pkg::APB_DATA_W-1:0] pwdata  = '0;
    logic [bb3_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;
    logic                           i_in_valid  = 1'b0;
    logic                           o_in_stall;
    logic                           i_action    = ACT_PIXEL;
    logic [bb3_pkg::CH_W-1:0]       i_red_in    = '0;
    logic [bb3_pkg::CH_W-1:0]       i_green_in  = '0;
    logic [bb3_pkg::CH_W-1:0]       i_blue_in   = '0;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    logic [bb3_pkg::CH_W-1:0]       o_red_out;
    logic [bb3_pkg::CH_W-1:0]       o_green_out;
    logic [bb3_pkg::CH_W-1:0]       o_blue_out;
    logic                           o_last_of_frame;

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          cycle_count    = 0;
    int          pending;
    int          fail_count;
    int unsigned frame_w = 640;
    int unsigned frame_h = 480;

    box_blur_3x3_rgb dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_red_in        (i_red_in),
        .i_green_in      (i_green_in),
        .i_blue_in       (i_blue_in),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_red_out       (o_red_out),
        .o_green_out     (o_green_out),
        .o_blue_out      (o_blue_out),
        .o_last_of_frame (o_last_of_frame)
    );

    blur_monitor mon (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .i_prdata        (prdata),
        .i_pready        (pready),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_red_in        (i_red_in),
        .i_green_in      (i_green_in),
        .i_blue_in       (i_blue_in),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_red_out       (o_red_out),
        .i_green_out     (o_green_out),
        .i_blue_out      (o_blue_out),
        .i_last_of_frame (o_last_of_frame),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic set_idle(idle_mode_t mode);
        case (mode)
            IDLE_SENDER_LIGHT: begin
                send_idle_pct  = 27;
                recv_stall_pct = 48;
            end
            IDLE_SENDER_HEAVY: begin
                send_idle_pct  = 48;
                recv_stall_pct = 27;
            end
            default: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
        endcase
    endtask

    // one input beat, held until taken
    task automatic push_beat(logic act, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_red_in   <= r;
        i_green_in <= g;
        i_blue_in  <= b;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
    endtask

    // hold off until every blurred pixel is out and the pipe has settled
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // setup then access cycle
    task automatic apb_access(logic wr, logic idx, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // new frame size; also rewinds the position counters
    task automatic set_frame(int unsigned w_raw, int unsigned h_raw);
        logic [19:0] junk_w;
        logic [18:0] junk_h;
        junk_w = $urandom_range(0, 1) ? 20'($urandom) : 20'd0;
        junk_h = $urandom_range(0, 1) ? 19'($urandom) : 19'd0;
        wait_drained();
        apb_access(1'b1, bb3_pkg::REG_FRAME_WIDTH, {junk_w, 12'(w_raw)});
        apb_access(1'b1, bb3_pkg::REG_FRAME_HEIGHT, {junk_h, 13'(h_raw)});
        apb_access(1'b0, bb3_pkg::REG_FRAME_WIDTH, '0);
        apb_access(1'b0, bb3_pkg::REG_FRAME_HEIGHT, '0);
        w_raw   = w_raw & 12'hFFF;
        h_raw   = h_raw & 13'h1FFF;
        frame_w = (w_raw == 0) ? 1 : (w_raw > MAXW) ? MAXW : w_raw;
        frame_h = (h_raw == 0) ? 1 : (h_raw > MAXH) ? MAXH : h_raw;
    endtask

    // mostly uniform, with the extremes now and then
    function automatic logic [7:0] rand_channel();
        case ($urandom_range(0, 19))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // n_items beats in raster order: pixels, then the flush steps;
    // noisy frames swap some pixels and flushes
    task automatic send_frame(int unsigned n_items, bit noisy, bit patterned);
        int unsigned p, pixels;
        logic        act;
        logic [7:0]  r, g, b;
        pixels = frame_w * frame_h;
        for (p = 0; p < n_items; p++) begin
            act = (p < pixels) ? ACT_PIXEL : ACT_FLUSH;
            if (noisy && $urandom_range(0, 9) == 0)
                act = (act == ACT_PIXEL) ? ACT_FLUSH : ACT_PIXEL;
            if (patterned) begin
                r = p[0] ? 8'hFF : 8'h00;
                g = 8'hFF - 8'(p * 29);
                b = 8'(p * 37 + 3);
            end else begin
                r = rand_channel();
                g = rand_channel();
                b = rand_channel();
            end
            push_beat(act, r, g, b);
        end
    endtask

    initial begin
        int unsigned sent, n, kind, frame_no, w_raw, h_raw;
        bit          rewind_due;
        set_idle(IDLE_SENDER_LIGHT);
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset values of both registers
        apb_access(1'b0, bb3_pkg::REG_FRAME_WIDTH, '0);
        apb_access(1'b0, bb3_pkg::REG_FRAME_HEIGHT, '0);

        // full 3x3 window: corner, edge and centre divisors
        set_frame(3, 3);
        send_frame(3 * 3 + 3 + 1, 1'b0, 1'b1);
        // single pixel frame
        set_frame(1, 1);
        send_frame(1 + 1 + 1, 1'b0, 1'b1);
        // single column: vertical-only neighbours
        set_frame(1, 3);
        send_frame(3 + 1 + 1, 1'b0, 1'b1);

        // random frames; two short bursts run at the clipped register extremes
        sent       = 0;
        frame_no   = 0;
        rewind_due = 1'b1;
        while (sent < RANDOM_ITEMS) begin
            if (sent < RANDOM_ITEMS / 3)
                set_idle(IDLE_SENDER_LIGHT);
            else if (sent < 2 * RANDOM_ITEMS / 3)
                set_idle(IDLE_SENDER_HEAVY);
            else
                set_idle(IDLE_NONE);

            if (frame_no == 1 || frame_no == 2) begin
                // cut short, rewound by the next register write
                if (frame_no == 1)
                    set_frame(4095, 0);
                else
                    set_frame(0, 8191);
                n = $urandom_range(20, 40);
                send_frame(n, 1'b0, 1'b0);
                sent      += n;
                rewind_due = 1'b1;
            end else begin
                if (rewind_due || $urandom_range(0, 1)) begin
                    w_raw = ($urandom_range(0, 19) == 0) ? 0 :
                            ($urandom_range(0, 4) == 0) ? $urandom_range(13, 64) :
                            $urandom_range(1, 12);
                    h_raw = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
                    set_frame(w_raw, h_raw);
                end
                kind = $urandom_range(0, 9);
                n    = frame_w * frame_h + frame_w + 1;
                // broken frame cut short, rewound by the next register write
                if (kind == 9)
                    n = $urandom_range(1, n);
                send_frame(n, kind == 7 || kind == 8, 1'b0);
                sent      += n;
                rewind_due = (kind == 9);
            end
            frame_no++;
        end

        wait_drained();
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
